>>> design/psdf_pkg.sv
`default_nettype none

package psdf_pkg;

    // Field widths
    localparam int CAR_W  = 8;
    localparam int MSG_W  = 16;
    localparam int DLY_W  = 16;
    localparam int TIME_W = 48;
    localparam int WIN_W  = 16;
    localparam int LAP_W  = 49;

    // Packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    // Repeat window after reset, in ms
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd4000;

    // Most negative lap time (-2^48)
    localparam logic [LAP_W-1:0] LAP_MIN = {1'b1, {(LAP_W-1){1'b0}}};

    // One table entry per source
    typedef struct packed {
        logic              valid;
        logic [MSG_W-1:0]  msg;
        logic [TIME_W-1:0] arrival;
    } t_entry;

    // Control sequence for one message
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> design/psdf_table.sv
`default_nettype none

module psdf_table #(
    parameter  int SLOTS  = 256,
    localparam int ADDR_W = $clog2(SLOTS)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_rd_en,
    input  wire  [ADDR_W-1:0]     i_rd_addr,
    output psdf_pkg::t_entry      o_rd_data,
    input  wire                   i_wr_en,
    input  wire  [ADDR_W-1:0]     i_wr_addr,
    input  psdf_pkg::t_entry      i_wr_data,
    output logic                  o_busy
);
    import psdf_pkg::*;

    t_entry              r_mem [SLOTS];
    t_entry              r_rd_data;
    logic                r_busy;
    logic [ADDR_W-1:0]   r_clr_addr;

    // Clearing sweep after reset: one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == ADDR_W'(SLOTS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Single write port, shared by the sweep and updates
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

>>> design/per_source_duplicate_filter.sv
`default_nettype none

// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  ----------------------------------------------
// s_axis   in   tvalid / tready        car_number, message_number, send_delay_ms,
//                                      arrival_time_ms
// m_axis   out  tvalid / tready        accepted, known_source, possible_loss,
//                                      lap_time_ms
// cfg      in   we (no ready)          repeat_window_ms
//
// Each message passes through accept and table read, evaluation of the elapsed time,
// then result and table write-back. The table read is registered, hence the evaluate step.
// After reset the table is swept clear with s_axis_tready low.
// A result waiting on m_axis does not block the next accept; a message that
// finishes while the previous result is still held waits in its last step.

module per_source_duplicate_filter #(
    parameter int CAR_SLOTS = 256
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // cfg
    input  wire                                i_cfg_we,
    input  wire  [psdf_pkg::WIN_W-1:0]         i_cfg_wdata,
    // s_axis
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] car_number, [23:8] message_number, [39:24] send_delay_ms,
    // [87:40] arrival_time_ms
    input  wire  [psdf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // m_axis
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [0] accepted, [1] known_source, [2] possible_loss, [51:3] lap_time_ms,
    // [55:52] zero
    output logic [psdf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import psdf_pkg::*;

    localparam int ADDR_W = $clog2(CAR_SLOTS);

    // Input field views
    logic [CAR_W-1:0]  in_car;
    logic [MSG_W-1:0]  in_msg;
    logic [DLY_W-1:0]  in_dly;
    logic [TIME_W-1:0] in_time;

    assign in_car  = i_s_axis_tdata[7:0];
    assign in_msg  = i_s_axis_tdata[23:8];
    assign in_dly  = i_s_axis_tdata[39:24];
    assign in_time = i_s_axis_tdata[87:40];

    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_window;

    // Captured message
    logic [ADDR_W-1:0]   r_addr;
    logic                r_in_table;
    logic [MSG_W-1:0]    r_msg;
    logic [DLY_W-1:0]    r_dly;
    logic [TIME_W-1:0]   r_time;

    // Evaluation results
    logic                r_known;
    logic                r_same;
    logic                r_loss;
    logic [LAP_W-1:0]    r_elapsed;

    // Output register
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Table interface
    t_entry              tbl_rd;
    t_entry              tbl_wr;
    logic                tbl_busy;
    logic                tbl_wr_en;

    logic                take_in;
    logic                out_free;
    logic                finish;
    logic                reject;
    logic                accept;
    logic [LAP_W:0]      lap_full;
    logic [LAP_W-1:0]    lap_sat;

    psdf_table #(
        .SLOTS(CAR_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (take_in),
        .i_rd_addr (ADDR_W'(in_car)),
        .o_rd_data (tbl_rd),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (tbl_wr),
        .o_busy    (tbl_busy)
    );

    // Repeat window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Decision and lap time, from the evaluated entry
    always_comb begin
        reject   = r_known && r_same &&
                   ($signed(r_elapsed) < $signed({{(LAP_W-WIN_W){1'b0}}, r_window}));
        accept   = !reject;
        lap_full = {r_elapsed[LAP_W-1], r_elapsed} - {{(LAP_W+1-DLY_W){1'b0}}, r_dly};
        if (lap_full[LAP_W:LAP_W-1] == 2'b10) begin
            lap_sat = LAP_MIN;
        end else begin
            lap_sat = lap_full[LAP_W-1:0];
        end
        tbl_wr = '{valid: 1'b1, msg: r_msg, arrival: r_time};
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        take_in         = 1'b0;
        finish          = 1'b0;
        tbl_wr_en       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = !tbl_busy;
                if (i_s_axis_tvalid && !tbl_busy) begin
                    take_in = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    finish    = 1'b1;
                    tbl_wr_en = accept && r_in_table;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the message on transfer
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_addr     <= ADDR_W'(in_car);
            r_in_table <= (32'(in_car) < CAR_SLOTS);
            r_msg      <= in_msg;
            r_dly      <= in_dly;
            r_time     <= in_time;
        end
    end

    // Compare against the stored entry
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL) begin
            r_known   <= r_in_table && tbl_rd.valid;
            r_same    <= (r_msg == tbl_rd.msg);
            r_loss    <= ({1'b0, r_msg} > ({1'b0, tbl_rd.msg} + 17'd1));
            r_elapsed <= {1'b0, r_time} - {1'b0, tbl_rd.arrival};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= {
                {(OUT_DATA_W-LAP_W-3){1'b0}},
                (r_known ? lap_sat : {LAP_W{1'b0}}),
                (r_known && !r_same && r_loss),
                r_known,
                accept
            };
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
